// ----- design/dbve_pkg.sv -----
package dbve_pkg;

  localparam int WORDS_DEFAULT     = 64;
  localparam int WORD_BITS_DEFAULT = 64;

  // field widths fixed by the interface
  localparam int VW_WIDTH      = 7;
  localparam int IDX_WIDTH     = 6;
  localparam int IN_WORD_WIDTH = 64;
  localparam int POS_WIDTH     = 12;

  localparam logic [VW_WIDTH-1:0] VW_RESET = 7'd64;

  // iterator scans one chunk of a word per cycle
  localparam int CHUNK_BITS  = 8;
  localparam int CHUNK_POS_W = $clog2(CHUNK_BITS);

  localparam int QUEUE_DEPTH = 2;

  // operation codes
  localparam logic [2:0] OP_CLEAR      = 3'd0;
  localparam logic [2:0] OP_SET_ALL    = 3'd1;
  localparam logic [2:0] OP_OR_WORD    = 3'd2;
  localparam logic [2:0] OP_GEN_KILL   = 3'd3;
  localparam logic [2:0] OP_ITER_START = 3'd4;
  localparam logic [2:0] OP_ITER_NEXT  = 3'd5;

  typedef struct packed {
    logic [2:0]               operation;
    logic [IDX_WIDTH-1:0]     word_addr;
    logic [IN_WORD_WIDTH-1:0] source_word;
    logic [IN_WORD_WIDTH-1:0] kill_word;
    logic                     pass_start;
  } cmd_t;

  typedef struct packed {
    logic                 changed;
    logic [POS_WIDTH-1:0] bit_position;
    logic                 iter_done;
  } result_t;

  // work classes handed from front to back
  typedef enum logic [2:0] {
    CLS_CLEAR,
    CLS_SET_ALL,
    CLS_MERGE,
    CLS_ITER_START,
    CLS_ITER_NEXT,
    CLS_NOP
  } cls_t;

  typedef struct packed {
    cls_t                     cls;
    logic [IDX_WIDTH-1:0]     word_addr;
    logic [IN_WORD_WIDTH-1:0] add_word;
    logic                     pass_start;
  } entry_t;

  // position of the lowest set bit of a chunk, zero when none
  function automatic logic [CHUNK_POS_W-1:0] lowest_set(input logic [CHUNK_BITS-1:0] b);
    logic [CHUNK_POS_W-1:0] pos;
    pos = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      if (b[i]) begin
        pos = CHUNK_POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- design/dbve_front.sv -----
module dbve_front #(
  parameter int WORD_BITS = dbve_pkg::WORD_BITS_DEFAULT
) (
  input  logic             start,
  input  dbve_pkg::cmd_t   cmd,
  input  logic             q_full,
  input  logic             init_busy,
  output logic             busy,
  output logic             push,
  output dbve_pkg::entry_t entry
);

  localparam logic [dbve_pkg::IN_WORD_WIDTH-1:0] WORD_MASK =
    {dbve_pkg::IN_WORD_WIDTH{1'b1}} >> (dbve_pkg::IN_WORD_WIDTH - WORD_BITS);

  assign busy = q_full | init_busy;
  assign push = start & ~busy;

  always_comb begin
    entry.word_addr  = cmd.word_addr;
    entry.pass_start = cmd.pass_start;
    // gen and not kill folds into one word to merge
    if (cmd.operation == dbve_pkg::OP_GEN_KILL) begin
      entry.add_word = cmd.source_word & ~cmd.kill_word & WORD_MASK;
    end else begin
      entry.add_word = cmd.source_word & WORD_MASK;
    end
    case (cmd.operation)
      dbve_pkg::OP_CLEAR:      entry.cls = dbve_pkg::CLS_CLEAR;
      dbve_pkg::OP_SET_ALL:    entry.cls = dbve_pkg::CLS_SET_ALL;
      dbve_pkg::OP_OR_WORD:    entry.cls = dbve_pkg::CLS_MERGE;
      dbve_pkg::OP_GEN_KILL:   entry.cls = dbve_pkg::CLS_MERGE;
      dbve_pkg::OP_ITER_START: entry.cls = dbve_pkg::CLS_ITER_START;
      dbve_pkg::OP_ITER_NEXT:  entry.cls = dbve_pkg::CLS_ITER_NEXT;
      default:                 entry.cls = dbve_pkg::CLS_NOP;
    endcase
  end

endmodule

// ----- design/dbve_queue.sv -----
module dbve_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dbve_pkg::entry_t entry_in,
  input  logic             pop,
  output dbve_pkg::entry_t entry_out,
  output logic             valid,
  output logic             full
);

  localparam int DEPTH = dbve_pkg::QUEUE_DEPTH;
  localparam int PW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  dbve_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign valid     = fill != '0;
  assign full      = fill == CW'(DEPTH);
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- design/dbve_back.sv -----
module dbve_back #(
  parameter int WORDS     = dbve_pkg::WORDS_DEFAULT,
  parameter int WORD_BITS = dbve_pkg::WORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dbve_pkg::VW_WIDTH-1:0] vector_words,
  input  logic                          q_valid,
  input  dbve_pkg::entry_t              q_entry,
  output logic                          q_pop,
  output logic                          init_busy,
  output logic                          result_valid,
  output dbve_pkg::result_t             result
);

  localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int CNT_W = $clog2(WORDS + 1);
  localparam int CMP_W = CNT_W > dbve_pkg::VW_WIDTH ? CNT_W : dbve_pkg::VW_WIDTH;
  localparam int NCH   = (WORD_BITS + dbve_pkg::CHUNK_BITS - 1) / dbve_pkg::CHUNK_BITS;
  localparam int SCW   = NCH > 1 ? $clog2(NCH) : 1;
  localparam int PAD_W = NCH * dbve_pkg::CHUNK_BITS;
  localparam int SEL_W = SCW + dbve_pkg::CHUNK_POS_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_RMW,
    ST_WALK,
    ST_FETCH,
    ST_SCAN
  } state_t;

  state_t state;

  logic [WORD_BITS-1:0] store [WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [AW-1:0]                    sweep;
  logic [WORD_BITS-1:0]             fill_val;
  logic [WORD_BITS-1:0]             add_word;
  logic                             pass_flag;
  logic [AW-1:0]                    wr_idx;
  logic [CNT_W-1:0]                 cursor_word;
  logic [dbve_pkg::POS_WIDTH-1:0]   cursor_bit;
  logic [WORD_BITS-1:0]             remaining;
  logic                             change_seen;
  logic [SCW-1:0]                   scan;
  logic                             pending;

  logic [CMP_W-1:0]                 vw_ext;
  logic [CMP_W-1:0]                 count_c;
  logic                             idx_ok;
  logic                             iter_done;
  logic [CNT_W-1:0]                 next_word;
  logic                             walk_end;
  logic [CMP_W-1:0]                 sweep_plus;
  logic [dbve_pkg::POS_WIDTH-1:0]   base;
  logic [PAD_W-1:0]                 padded;
  logic [dbve_pkg::CHUNK_BITS-1:0]  chunk;
  logic [SEL_W-1:0]                 bit_sel;
  logic [WORD_BITS-1:0]             merged;
  logic                             differs;

  always_comb begin
    vw_ext     = CMP_W'(vector_words);
    count_c    = (vw_ext > CMP_W'(WORDS)) ? CMP_W'(WORDS) : vw_ext;
    idx_ok     = CMP_W'(q_entry.word_addr) < count_c;
    iter_done  = CMP_W'(cursor_word) >= count_c;
    next_word  = cursor_word + 1'b1;
    walk_end   = CMP_W'(next_word) >= count_c;
    sweep_plus = CMP_W'(sweep) + CMP_W'(1);
    base       = dbve_pkg::POS_WIDTH'(cursor_word * WORD_BITS);
    padded     = PAD_W'(remaining);
    chunk      = padded[scan * dbve_pkg::CHUNK_BITS +: dbve_pkg::CHUNK_BITS];
    bit_sel    = {scan, dbve_pkg::lowest_set(chunk)};
    merged     = rd_data | add_word;
    differs    = merged != rd_data;
  end

  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign init_busy = state == ST_INIT;

  // memory port control
  always_comb begin
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = '0;
    case (state)
      ST_IDLE: begin
        if (q_entry.cls != dbve_pkg::CLS_ITER_START) begin
          rd_addr = AW'(q_entry.word_addr);
        end
      end
      ST_WALK: rd_addr = AW'(next_word);
      ST_INIT: mem_we = 1'b1;
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_val;
      end
      ST_RMW: begin
        mem_we    = differs;
        mem_waddr = wr_idx;
        mem_wdata = merged;
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      sweep        <= '0;
      cursor_word  <= '0;
      cursor_bit   <= '0;
      remaining    <= '0;
      change_seen  <= 1'b0;
      scan         <= '0;
      pending      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pending) begin
            result_valid        <= 1'b1;
            result.changed      <= change_seen;
            result.iter_done    <= iter_done;
            result.bit_position <= iter_done ? '0 : cursor_bit;
            pending             <= 1'b0;
          end
          if (q_valid) begin
            case (q_entry.cls)
              dbve_pkg::CLS_CLEAR, dbve_pkg::CLS_SET_ALL: begin
                fill_val <= (q_entry.cls == dbve_pkg::CLS_SET_ALL) ? '1 : '0;
                sweep    <= '0;
                if (count_c == '0) begin
                  pending <= 1'b1;
                end else begin
                  state <= ST_FILL;
                end
              end
              dbve_pkg::CLS_MERGE: begin
                add_word  <= WORD_BITS'(q_entry.add_word);
                pass_flag <= q_entry.pass_start;
                wr_idx    <= AW'(q_entry.word_addr);
                if (idx_ok) begin
                  state <= ST_RMW;
                end else begin
                  if (q_entry.pass_start) begin
                    change_seen <= 1'b0;
                  end
                  pending <= 1'b1;
                end
              end
              dbve_pkg::CLS_ITER_START: begin
                cursor_word <= '0;
                if (count_c == '0) begin
                  remaining  <= '0;
                  cursor_bit <= '1;
                  pending    <= 1'b1;
                end else begin
                  cursor_bit <= '0;
                  state      <= ST_FETCH;
                end
              end
              dbve_pkg::CLS_ITER_NEXT: begin
                if (iter_done) begin
                  pending <= 1'b1;
                end else begin
                  cursor_bit <= cursor_bit + 1'b1;
                  scan       <= '0;
                  state      <= (remaining == '0) ? ST_WALK : ST_SCAN;
                end
              end
              default: pending <= 1'b1;
            endcase
          end
        end
        ST_FILL: begin
          sweep <= sweep + 1'b1;
          if (sweep_plus == count_c) begin
            pending <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        ST_RMW: begin
          if (differs) begin
            change_seen <= 1'b1;
          end else if (pass_flag) begin
            change_seen <= 1'b0;
          end
          pending <= 1'b1;
          state   <= ST_IDLE;
        end
        ST_WALK: begin
          cursor_word <= next_word;
          if (walk_end) begin
            pending <= 1'b1;
            state   <= ST_IDLE;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          remaining <= rd_data;
          scan      <= '0;
          state     <= (rd_data == '0) ? ST_WALK : ST_SCAN;
        end
        ST_SCAN: begin
          if (chunk != '0) begin
            cursor_bit <= base + dbve_pkg::POS_WIDTH'(bit_sel);
            remaining  <= remaining & ~(WORD_BITS'(1) << bit_sel);
            pending    <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/dataflow_bit_vector_engine.sv -----
// Gen/kill bit vector engine. A command beat is taken on start while busy is low; every
// command gives exactly one result beat, shown for one cycle under result_valid, and the
// receiver cannot stall it. Results come back in command order. Commands go through a
// two-entry queue into a sequencer that owns the word memory, so the rate is set by
// that sequencer: an or-word or gen/kill update reads the word, then writes it back in
// the RMW state if it changed; clear and set-all sweep the words in use in turn; an
// iterator step is dispatched from idle, then for each word it moves on to it walks to
// that word and fetches it (an iter start fetches word 0 at once), scans the 8-bit
// chunks of the word holding the next set bit in turn (up to WORD_BITS/8), or ends when
// it runs off the last word in use. Out-of-range word operations, unused codes and
// iterator steps once done are answered from the idle state. After reset the store is
// cleared one word per cycle with busy held high; the word count register may be
// written during that time but only while no command is outstanding otherwise.
module dataflow_bit_vector_engine #(
  parameter int WORDS     = dbve_pkg::WORDS_DEFAULT,
  parameter int WORD_BITS = dbve_pkg::WORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  dbve_pkg::cmd_t                cmd,
  output logic                          result_valid,
  output dbve_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dbve_pkg::VW_WIDTH-1:0] cfg_data
);

  // word count register, saturated to WORDS inside the back end
  logic [dbve_pkg::VW_WIDTH-1:0] vector_words;

  // front to queue
  logic             push;
  dbve_pkg::entry_t push_entry;

  // queue to back end
  logic             q_valid;
  logic             q_full;
  logic             q_pop;
  dbve_pkg::entry_t q_entry;

  // high during the clearing pass after reset
  logic init_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_words <= dbve_pkg::VW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vector_words <= cfg_data;
    end
  end

  // front: takes command beats and folds them into work entries
  dbve_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .start     (start),
    .cmd       (cmd),
    .q_full    (q_full),
    .init_busy (init_busy),
    .busy      (busy),
    .push      (push),
    .entry     (push_entry)
  );

  // short queue so front and back stall on their own
  dbve_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (push_entry),
    .pop       (q_pop),
    .entry_out (q_entry),
    .valid     (q_valid),
    .full      (q_full)
  );

  // back: memory sequencer, iterator and result register
  dbve_back #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .vector_words (vector_words),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef ASSERT_OFF
  // the queue must never be pushed when it has no room
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("command queue pushed while full");

  // the clearing pass holds off commands right after reset
  assert property (@(posedge clk) !rst && $past(rst) |-> busy)
    else $error("busy low right after reset");

  // no result beat can leave while the store is still being cleared
  assert property (@(posedge clk) disable iff (rst) init_busy |-> !result_valid)
    else $error("result beat during clearing pass");
`endif

endmodule

// ----- verif/dataflow_bit_vector_engine_test.sv -----
`timescale 1ns / 100ps

module dataflow_bit_vector_engine_test;

  localparam int WORDS     = dbve_pkg::WORDS_DEFAULT;
  localparam int WORD_BITS = dbve_pkg::WORD_BITS_DEFAULT;
  localparam int MW        = $clog2(WORDS);

  // operation codes under short names
  localparam logic [2:0] OP_CLEAR      = dbve_pkg::OP_CLEAR;
  localparam logic [2:0] OP_SET_ALL    = dbve_pkg::OP_SET_ALL;
  localparam logic [2:0] OP_OR_WORD    = dbve_pkg::OP_OR_WORD;
  localparam logic [2:0] OP_GEN_KILL   = dbve_pkg::OP_GEN_KILL;
  localparam logic [2:0] OP_ITER_START = dbve_pkg::OP_ITER_START;
  localparam logic [2:0] OP_ITER_NEXT  = dbve_pkg::OP_ITER_NEXT;

  // codes the block leaves unused
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

  // a walk across all words plus a full chunk scan, with margin
  localparam int DRAIN_CYCLES   = 200;
  localparam int TIMEOUT_NS     = 5_000_000;
  localparam int PHASES         = 9;
  localparam int ITEMS_PER_PASS = 68;

  // word counts per random phase, the extremes among them
  localparam logic [dbve_pkg::VW_WIDTH-1:0] PHASE_COUNTS [PHASES] = '{
    7'd1, 7'd0, 7'd127, 7'd64, 7'd3, 7'd0, 7'd17, 7'd0, 7'd64
  };

  // one row of directed stimulus; typed rows carry the result to expect
  typedef struct packed {
    dbve_pkg::cmd_t    c;
    logic              typed;
    dbve_pkg::result_t want;
  } row_t;

  localparam int N_ROWS = 25;

  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    // spare codes right after reset: status of the reset state
    '{'{OP_SPARE_LO, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b0, 12'd0, 1'b0}},
    '{'{OP_SPARE_HI, 6'd63, ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{1'b0, 12'd0, 1'b0}},
    // next before any start, then start on an empty store
    '{'{OP_ITER_NEXT, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b0, 12'd0, 1'b1}},
    '{'{OP_ITER_START, 6'd0, 64'd0, 64'd0, 1'b1}, 1'b1, '{1'b0, 12'd0, 1'b1}},
    // word ops at both ends of the index range
    '{'{OP_OR_WORD, 6'd0, ALL_ONES, 64'd0, 1'b1}, 1'b1, '{1'b1, 12'd0, 1'b1}},
    '{'{OP_OR_WORD, 6'd63, 64'd0, ALL_ONES, 1'b1}, 1'b1, '{1'b0, 12'd0, 1'b1}},
    '{'{OP_GEN_KILL, 6'd63, ALL_ONES, ALL_ONES, 1'b0}, 1'b1, '{1'b0, 12'd0, 1'b1}},
    '{'{OP_GEN_KILL, 6'd63, ALL_ONES, ~TOP_BIT, 1'b0}, 1'b1, '{1'b1, 12'd0, 1'b1}},
    '{'{OP_ITER_START, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b1, 12'd0, 1'b0}},
    '{'{OP_ITER_NEXT, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b0, '0},
    // clear and set all leave the flag and the cursor alone
    '{'{OP_CLEAR, 6'd0, ALL_ONES, ALL_ONES, 1'b1}, 1'b0, '0},
    '{'{OP_SET_ALL, 6'd0, 64'd0, 64'd0, 1'b1}, 1'b0, '0},
    '{'{OP_CLEAR, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b0, '0},
    '{'{OP_ITER_START, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b1, 12'd0, 1'b1}},
    '{'{OP_GEN_KILL, 6'd5, ALL_ONES, ~64'h80, 1'b1}, 1'b0, '0},
    '{'{OP_ITER_START, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b0, '0},
    '{'{OP_ITER_NEXT, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b0, '0},
    // next once done keeps the iterator where it is
    '{'{OP_ITER_NEXT, 6'd0, 64'd0, 64'd0, 1'b1}, 1'b0, '0},
    '{'{OP_GEN_KILL, 6'd0, 64'h5555_5555_5555_5555, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0}, 1'b0, '0},
    '{'{OP_CLEAR, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b0, '0},
    // highest bit of the highest word
    '{'{OP_OR_WORD, 6'd63, TOP_BIT, 64'd0, 1'b1}, 1'b1, '{1'b1, 12'd0, 1'b1}},
    '{'{OP_ITER_START, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b1, 12'd4095, 1'b0}},
    '{'{OP_ITER_NEXT, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b1, '{1'b1, 12'd0, 1'b1}},
    // leave the cursor parked in word 40 for the shrink that follows
    '{'{OP_OR_WORD, 6'd40, 64'h8, 64'd0, 1'b0}, 1'b0, '0},
    '{'{OP_ITER_START, 6'd0, 64'd0, 64'd0, 1'b0}, 1'b0, '0}
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  dbve_pkg::cmd_t                cmd;
  logic                          result_valid;
  dbve_pkg::result_t             result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [dbve_pkg::VW_WIDTH-1:0] cfg_data;

  // typed expectation that travels with the command beat
  logic              row_typed;
  dbve_pkg::result_t row_want;

  // mirror of the engine state
  logic [WORD_BITS-1:0]          mirror_words [WORDS];
  logic [6:0]                    mirror_cursor_word;
  logic [WORD_BITS-1:0]          mirror_remaining;
  logic [12:0]                   mirror_cursor_bit;
  logic                          mirror_changed;
  logic [dbve_pkg::VW_WIDTH-1:0] mirror_count;

  dbve_pkg::result_t pending_results [$];

  int mismatch_count;
  int accepted_count;
  int checked_count;
  int done_count;
  int count_writes;
  int sender_gap_pct;

  dataflow_bit_vector_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // words in use, saturated at the store size
  function automatic logic [6:0] words_in_use();
    return (mirror_count > 7'(WORDS)) ? 7'(WORDS) : mirror_count;
  endfunction

  // step the cursor to the next set bit, skipping zero words
  function automatic void advance_cursor();
    logic [6:0] n;
    n = words_in_use();
    if (mirror_cursor_word >= n) begin
      return;
    end
    mirror_cursor_bit = mirror_cursor_bit + 13'd1;
    if (mirror_remaining == '0) begin
      do begin
        mirror_cursor_word = mirror_cursor_word + 7'd1;
        if (mirror_cursor_word >= n) begin
          return;
        end
        mirror_remaining = mirror_words[mirror_cursor_word[MW-1:0]];
      end while (mirror_remaining == '0);
      mirror_cursor_bit = 13'(mirror_cursor_word * WORD_BITS);
    end
    while (mirror_remaining[0] == 1'b0) begin
      mirror_remaining  = mirror_remaining >> 1;
      mirror_cursor_bit = mirror_cursor_bit + 13'd1;
    end
    mirror_remaining = mirror_remaining >> 1;
  endfunction

  // or a word into the store; out-of-use indexes are dropped
  function automatic void merge_word(logic [dbve_pkg::IDX_WIDTH-1:0] idx,
                                     logic [WORD_BITS-1:0] add);
    logic [WORD_BITS-1:0] merged;
    if ({1'b0, idx} >= words_in_use()) begin
      return;
    end
    merged = mirror_words[idx] | add;
    if (merged != mirror_words[idx]) begin
      mirror_words[idx] = merged;
      mirror_changed    = 1'b1;
    end
  endfunction

  // engine status after one command beat
  function automatic dbve_pkg::result_t engine_status_after(dbve_pkg::cmd_t c);
    logic [6:0]        n;
    logic              done;
    dbve_pkg::result_t r;
    n = words_in_use();
    case (c.operation)
      OP_CLEAR: begin
        for (int i = 0; i < WORDS; i++) begin
          if (i < n) mirror_words[i] = '0;
        end
      end
      OP_SET_ALL: begin
        for (int i = 0; i < WORDS; i++) begin
          if (i < n) mirror_words[i] = '1;
        end
      end
      OP_OR_WORD: begin
        if (c.pass_start) mirror_changed = 1'b0;
        merge_word(c.word_addr, c.source_word);
      end
      OP_GEN_KILL: begin
        if (c.pass_start) mirror_changed = 1'b0;
        merge_word(c.word_addr, c.source_word & ~c.kill_word);
      end
      OP_ITER_START: begin
        mirror_cursor_word = '0;
        mirror_remaining   = (n > 0) ? mirror_words[0] : '0;
        mirror_cursor_bit  = '1;
        if (n > 0) advance_cursor();
      end
      OP_ITER_NEXT: begin
        advance_cursor();
      end
      default: begin
      end
    endcase
    done           = (mirror_cursor_word >= n);
    r.changed      = mirror_changed;
    r.iter_done    = done;
    r.bit_position = done ? '0 : mirror_cursor_bit[dbve_pkg::POS_WIDTH-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // track accepted beats and score result beats in one place, so a push and
  // a pop at the same edge cannot race
  always @(posedge clk) begin
    dbve_pkg::result_t want;
    if (rst) begin
      for (int i = 0; i < WORDS; i++) begin
        mirror_words[i] = '0;
      end
      mirror_cursor_word = '0;
      mirror_remaining   = '0;
      mirror_cursor_bit  = '0;
      mirror_changed     = 1'b0;
      mirror_count       = dbve_pkg::VW_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mirror_count = cfg_data;
      end
      if (start && !busy) begin
        want = engine_status_after(cmd);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
        accepted_count++;
      end
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (want.iter_done) done_count++;
          if (result.changed !== want.changed) begin
            report_mismatch("changed", result.changed, want.changed);
          end
          if (result.bit_position !== want.bit_position) begin
            report_mismatch("bit_position", result.bit_position, want.bit_position);
          end
          if (result.iter_done !== want.iter_done) begin
            report_mismatch("iter_done", result.iter_done, want.iter_done);
          end
        end
      end
    end
  end

  // offer one command beat, with random sender gaps ahead of it
  task automatic send_command(input dbve_pkg::cmd_t c, input logic typed,
                              input dbve_pkg::result_t want);
    while ($urandom_range(99, 0) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= c;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_count(input logic [dbve_pkg::VW_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_writes++;
  endtask

  // mix of empty, full, one-hot, sparse and dense words
  function automatic logic [63:0] random_word();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63, 0);
      3:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    dbve_pkg::cmd_t c;
    int             issued;
    int             pick;
    int             steps;
    int             in_use_now;

    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    row_typed      = 1'b0;
    row_want       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    mismatch_count = 0;
    accepted_count = 0;
    checked_count  = 0;
    done_count     = 0;
    count_writes   = 0;
    sender_gap_pct = 13;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset word count
    for (int r = 0; r < N_ROWS; r++) begin
      send_command(DIRECTED_ROWS[r].c, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    // shrink the count under a cursor parked in word 40: the walk ends early
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
    write_count(7'd20);
    c           = '0;
    c.operation = OP_ITER_NEXT;
    send_command(c, 1'b0, '0);

    for (int p = 0; p < PHASES; p++) begin
      sender_gap_pct = (p < 3) ? 13 : (p < 6) ? 56 : 0;

      // drain before touching the count
      start <= 1'b0;
      do @(negedge clk); while (pending_results.size() != 0);
      @(posedge clk);
      if (p == 5 || p == 7) begin
        write_count(7'($urandom_range(127, 1)));
      end else begin
        write_count(PHASE_COUNTS[p]);
      end
      in_use_now = words_in_use();

      issued = 0;
      while (issued < ITEMS_PER_PASS) begin
        // every field random first, then shaped by the kind of beat
        c.operation   = 3'($urandom_range(7, 0));
        c.word_addr   = 6'($urandom_range(63, 0));
        c.source_word = {$urandom, $urandom};
        c.kill_word   = {$urandom, $urandom};
        c.pass_start  = 1'($urandom_range(1, 0));
        pick          = $urandom_range(99, 0);
        if (pick < 40) begin
          // update within the words in use, mostly
          c.operation   = $urandom_range(1, 0) ? OP_OR_WORD : OP_GEN_KILL;
          c.source_word = random_word();
          c.kill_word   = random_word();
          c.pass_start  = ($urandom_range(3, 0) == 0);
          if (in_use_now > 0 && $urandom_range(9, 0) != 0) begin
            c.word_addr = 6'($urandom_range(in_use_now - 1, 0));
          end
          send_command(c, 1'b0, '0);
          issued++;
        end else if (pick < 55) begin
          // a walk: start then a run of next steps
          c.operation = OP_ITER_START;
          send_command(c, 1'b0, '0);
          steps = $urandom_range(8, 1);
          c.operation = OP_ITER_NEXT;
          repeat (steps) send_command(c, 1'b0, '0);
          issued += steps + 1;
        end else if (pick < 75) begin
          c.operation = OP_ITER_NEXT;
          send_command(c, 1'b0, '0);
          issued++;
        end else if (pick < 81) begin
          c.operation = OP_CLEAR;
          send_command(c, 1'b0, '0);
          issued++;
        end else if (pick < 84) begin
          c.operation = OP_SET_ALL;
          send_command(c, 1'b0, '0);
          issued++;
        end else begin
          // noise: any code, any fields
          send_command(c, 1'b0, '0);
          issued++;
        end
      end
    end

    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d command beats, %0d result beats scored, %0d iterator ends",
             accepted_count, checked_count, done_count);
    $display("tb: %0d word count settings from 0 to 127, sender gaps of 13, 56 and 0 pct",
             count_writes);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
